// ===== rtl/core/wsaf_pkg.sv =====
// Package for the windowed sum/average block: widths and state, command, status,
// bound and register codes. Used by windowed_sum_avg_frame_top; depends on nothing.
package wsaf_pkg;

  localparam int unsigned OUT_W  = 42;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned IN_W   = 32;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NULL    = 2'd1,
    STAT_ORDER   = 2'd2,
    STAT_NOT_LDD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_AGG_KIND   = 3'd0,
    REG_DISTINCT   = 3'd1,
    REG_START_KIND = 3'd2,
    REG_START_OFS  = 3'd3,
    REG_END_KIND   = 3'd4,
    REG_END_OFS    = 3'd5
  } reg_idx_e;

  // Bound kinds; any other code is unbounded on that side
  typedef enum logic [2:0] {
    BND_UNB_PREC = 3'd0,
    BND_UNB_FOLL = 3'd1,
    BND_CURRENT  = 3'd2,
    BND_PREC     = 3'd3,
    BND_FOLL     = 3'd4
  } bound_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_RD,
    ST_W_ACC,
    ST_D_RDI,
    ST_D_CHKI,
    ST_D_RDJ,
    ST_D_CHKJ,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/wsaf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsaf_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/wsaf_div.sv =====
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. No dependencies.
module wsaf_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned SW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [SW-1:0]    step_q, step_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One trial subtraction per cycle
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NUM_W-1];
      quo_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d = {quo_q[NUM_W-2:0], ge};
      step_d = step_q + SW'(1);
      if (step_q == SW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/core/windowed_sum_avg_frame_top.sv =====
// Top level of the windowed sum/average block: column store, frame and
// distinct sequencer. Depends on wsaf_pkg, wsaf_ram and wsaf_div.
//
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------
// request  | in        | start_i, busy_o          | command, first_element, sample_*,
//          |           |                          | query_row
// result   | out       | result_valid_o (pulse)   | aggregate_value_o, result_status_o
// config   | in        | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load leaves busy_o low. A window query uses a read state and an
// accumulate state per frame row through the single store read port; a
// distinct query reads every row and compares each present row with the
// earlier rows until a match. Both then pass a finish state, for averages
// the bit-serial divider, and a done state. A query to a row not loaded,
// or a window query with an empty or misordered frame, goes straight to the
// done state. Reset clears control state and the loaded row count; the store
// needs no clearing. The result is shown for one cycle and cannot be stalled.
module windowed_sum_avg_frame_top #(
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 command_i,
  input  logic                                 first_element_i,
  input  logic signed [wsaf_pkg::IN_W-1:0]     sample_value_i,
  input  logic                                 sample_present_i,
  input  logic [wsaf_pkg::ROW_W-1:0]           query_row_i,
  output logic                                 result_valid_o,
  output logic signed [wsaf_pkg::OUT_W-1:0]    aggregate_value_o,
  output logic [1:0]                           result_status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wsaf_pkg::CFG_AW-1:0]          cfg_index_i,
  input  logic [wsaf_pkg::CFG_DW-1:0]          cfg_data_i
);

  localparam int unsigned SW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned AW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned ACC_W = SW + AW + 1;
  localparam int unsigned XW    = (ACC_W > wsaf_pkg::OUT_W) ? ACC_W : wsaf_pkg::OUT_W;
  localparam int unsigned FW    = ((CW > 17) ? CW : 17) + 2;
  localparam logic signed [XW-1:0] SAT_HI = (XW'(1) << (wsaf_pkg::OUT_W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  wsaf_pkg::state_e state_q, state_d;

  // Configuration registers
  logic        agg_kind_q, distinct_q;
  logic [2:0]  s_kind_q, e_kind_q;
  logic [15:0] s_ofs_q, e_ofs_q;

  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           i_q, i_d, j_q, j_d, cnt_q, cnt_d, e_q, e_d;
  logic signed [ACC_W-1:0] sum_q, sum_d;
  logic [SW-1:0]           vi_q, vi_d;
  logic signed [wsaf_pkg::OUT_W-1:0] agg_q, agg_d;
  logic [1:0]              stat_q, stat_d;

  logic              accept, is_query, is_load;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [SW:0]       rdata;
  logic              rd_present;
  logic [SW-1:0]     rd_value;
  logic              div_start, div_done;
  logic signed [ACC_W-1:0] div_quo;
  logic signed [ACC_W-1:0] sat_src;
  logic signed [XW-1:0]    sat_ext;
  logic signed [wsaf_pkg::OUT_W-1:0] sat_val;

  // Frame bounds
  logic signed [FW-1:0] row_s, n_s, fs, fe, fs_clip, fe_clip;
  logic                 row_bad, order_bad, frame_empty;

  assign accept   = start_i && !busy_o;
  assign is_query = accept && (command_i == wsaf_pkg::CMD_QUERY);
  assign is_load  = accept && (command_i == wsaf_pkg::CMD_LOAD);

  assign rd_present = rdata[SW];
  assign rd_value   = rdata[SW-1:0];

  // Frame start/end from the bound kinds
  always_comb begin
    row_s = $signed(FW'(query_row_i));
    n_s   = $signed(FW'(count_q));
    unique case (s_kind_q)
      wsaf_pkg::BND_CURRENT: fs = row_s;
      wsaf_pkg::BND_PREC:    fs = row_s - $signed(FW'(s_ofs_q));
      wsaf_pkg::BND_FOLL:    fs = row_s + $signed(FW'(s_ofs_q));
      default:               fs = '0;
    endcase
    unique case (e_kind_q)
      wsaf_pkg::BND_CURRENT: fe = row_s;
      wsaf_pkg::BND_PREC:    fe = row_s - $signed(FW'(e_ofs_q));
      wsaf_pkg::BND_FOLL:    fe = row_s + $signed(FW'(e_ofs_q));
      default:               fe = n_s - $signed(FW'(1));
    endcase
    row_bad     = (row_s >= n_s);
    order_bad   = (fs > fe);
    frame_empty = (fs >= n_s) || (fe < $signed(FW'(0)));
    fs_clip     = (fs < $signed(FW'(0))) ? '0 : fs;
    fe_clip     = (fe >= n_s) ? (n_s - $signed(FW'(1))) : fe;
  end

  // Saturation to the result width
  assign sat_src = (state_q == wsaf_pkg::ST_DIV) ? div_quo : sum_q;
  always_comb begin
    sat_ext = XW'(sat_src);
    if (sat_ext > SAT_HI) begin
      sat_val = wsaf_pkg::OUT_W'(SAT_HI);
    end else if (sat_ext < SAT_LO) begin
      sat_val = wsaf_pkg::OUT_W'(SAT_LO);
    end else begin
      sat_val = wsaf_pkg::OUT_W'(sat_ext);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsaf_pkg::ST_IDLE: begin
        if (is_query) begin
          if (row_bad) begin
            state_d = wsaf_pkg::ST_DONE;
          end else if (distinct_q) begin
            state_d = wsaf_pkg::ST_D_RDI;
          end else if (order_bad || frame_empty) begin
            state_d = wsaf_pkg::ST_DONE;
          end else begin
            state_d = wsaf_pkg::ST_W_RD;
          end
        end
      end
      wsaf_pkg::ST_W_RD:  state_d = wsaf_pkg::ST_W_ACC;
      wsaf_pkg::ST_W_ACC: state_d = (i_q == e_q) ? wsaf_pkg::ST_FIN : wsaf_pkg::ST_W_RD;
      wsaf_pkg::ST_D_RDI: state_d = wsaf_pkg::ST_D_CHKI;
      wsaf_pkg::ST_D_CHKI: begin
        if (rd_present && (i_q != '0)) begin
          state_d = wsaf_pkg::ST_D_RDJ;
        end else begin
          state_d = (i_q + CW'(1) == count_q) ? wsaf_pkg::ST_FIN : wsaf_pkg::ST_D_RDI;
        end
      end
      wsaf_pkg::ST_D_RDJ: state_d = wsaf_pkg::ST_D_CHKJ;
      wsaf_pkg::ST_D_CHKJ: begin
        if ((rd_present && (rd_value == vi_q)) || (j_q + CW'(1) == i_q)) begin
          state_d = (i_q + CW'(1) == count_q) ? wsaf_pkg::ST_FIN : wsaf_pkg::ST_D_RDI;
        end else begin
          state_d = wsaf_pkg::ST_D_RDJ;
        end
      end
      wsaf_pkg::ST_FIN: begin
        if (cnt_q == '0 || !agg_kind_q) begin
          state_d = wsaf_pkg::ST_DONE;
        end else begin
          state_d = wsaf_pkg::ST_DIV;
        end
      end
      wsaf_pkg::ST_DIV:  state_d = div_done ? wsaf_pkg::ST_DONE : wsaf_pkg::ST_DIV;
      wsaf_pkg::ST_DONE: state_d = wsaf_pkg::ST_IDLE;
      default:           state_d = wsaf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    e_d       = e_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    vi_d      = vi_q;
    agg_d     = agg_q;
    stat_d    = stat_q;
    we        = 1'b0;
    waddr     = count_q[AW-1:0];
    raddr     = i_q[AW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      wsaf_pkg::ST_IDLE: begin
        if (is_load) begin
          if (first_element_i) begin
            we      = 1'b1;
            waddr   = '0;
            count_d = CW'(1);
          end else if (count_q != CW'(MAX_ROWS)) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        if (is_query) begin
          sum_d  = '0;
          cnt_d  = '0;
          agg_d  = '0;
          stat_d = wsaf_pkg::STAT_OK;
          i_d    = distinct_q ? '0 : CW'(fs_clip);
          e_d    = CW'(fe_clip);
          if (row_bad) begin
            stat_d = wsaf_pkg::STAT_NOT_LDD;
          end else if (!distinct_q && order_bad) begin
            stat_d = wsaf_pkg::STAT_ORDER;
          end else if (!distinct_q && frame_empty) begin
            stat_d = wsaf_pkg::STAT_NULL;
          end
        end
      end
      wsaf_pkg::ST_W_ACC: begin
        if (rd_present) begin
          sum_d = sum_q + ACC_W'($signed(rd_value));
          cnt_d = cnt_q + CW'(1);
        end
        i_d = i_q + CW'(1);
      end
      wsaf_pkg::ST_D_CHKI: begin
        vi_d = rd_value;
        j_d  = '0;
        if (!rd_present) begin
          i_d = i_q + CW'(1);
        end else if (i_q == '0) begin
          sum_d = sum_q + ACC_W'($signed(rd_value));
          cnt_d = cnt_q + CW'(1);
          i_d   = i_q + CW'(1);
        end
      end
      wsaf_pkg::ST_D_RDJ: raddr = j_q[AW-1:0];
      wsaf_pkg::ST_D_CHKJ: begin
        j_d = j_q + CW'(1);
        if (rd_present && (rd_value == vi_q)) begin
          i_d = i_q + CW'(1);
        end else if (j_q + CW'(1) == i_q) begin
          sum_d = sum_q + ACC_W'($signed(vi_q));
          cnt_d = cnt_q + CW'(1);
          i_d   = i_q + CW'(1);
        end
      end
      wsaf_pkg::ST_FIN: begin
        if (cnt_q == '0) begin
          stat_d = wsaf_pkg::STAT_NULL;
        end else if (!agg_kind_q) begin
          agg_d = sat_val;
        end else begin
          div_start = 1'b1;
        end
      end
      wsaf_pkg::ST_DIV: begin
        if (div_done) begin
          agg_d = sat_val;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wsaf_pkg::ST_IDLE;
      count_q    <= '0;
      agg_kind_q <= 1'b0;
      distinct_q <= 1'b0;
      s_kind_q   <= wsaf_pkg::BND_UNB_PREC;
      s_ofs_q    <= '0;
      e_kind_q   <= wsaf_pkg::BND_UNB_FOLL;
      e_ofs_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wsaf_pkg::REG_AGG_KIND:   agg_kind_q <= cfg_data_i[0];
          wsaf_pkg::REG_DISTINCT:   distinct_q <= cfg_data_i[0];
          wsaf_pkg::REG_START_KIND: s_kind_q   <= cfg_data_i[2:0];
          wsaf_pkg::REG_START_OFS:  s_ofs_q    <= cfg_data_i;
          wsaf_pkg::REG_END_KIND:   e_kind_q   <= cfg_data_i[2:0];
          wsaf_pkg::REG_END_OFS:    e_ofs_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    e_q    <= e_d;
    cnt_q  <= cnt_d;
    sum_q  <= sum_d;
    vi_q   <= vi_d;
    agg_q  <= agg_d;
    stat_q <= stat_d;
  end

  wsaf_ram #(
    .WIDTH (SW + 1),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({sample_present_i, sample_value_i[SW-1:0]}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wsaf_div #(
    .NUM_W (ACC_W),
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign busy_o            = (state_q != wsaf_pkg::ST_IDLE);
  assign result_valid_o    = (state_q == wsaf_pkg::ST_DONE);
  assign aggregate_value_o = agg_q;
  assign result_status_o   = stat_q;
  assign cfg_ready_o       = 1'b1;

  // A query always leaves the idle state
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == wsaf_pkg::CMD_QUERY) |=> busy_o)
    else $error("query did not start");

  // Non-ok results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_status_o != wsaf_pkg::STAT_OK) |-> (aggregate_value_o == '0))
    else $error("error result with nonzero value");

  // One strobe per query, then back to idle
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy_o))
    else $error("result strobe longer than one cycle");

  // Loads never start the sequencer
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == wsaf_pkg::CMD_LOAD) |=> !busy_o)
    else $error("load made the block busy");

endmodule
